FILE: sv/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants of the movetext tokenizer
// Lexer modes, prefix phases, token tracking state, result strings and the
// helpers that classify a finished token.
// ----------------------------------------------------------------------------
package mtt_pkg;

  typedef enum logic [2:0] {
    MODE_BETWEEN     = 3'd0,
    MODE_TOKEN       = 3'd1,
    MODE_COMMENT     = 3'd2,
    MODE_VARIATION   = 3'd3,
    MODE_VAR_COMMENT = 3'd4,
    MODE_NAG         = 3'd5
  } lex_mode_t;

  typedef enum logic [1:0] {
    PH_DIGITS = 2'd0,
    PH_DOTS   = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // result string matcher: alive mask and bytes seen (saturates at 8)
  typedef struct packed {
    logic [3:0] alive;
    logic [3:0] cnt;
  } cand_t;

  typedef struct packed {
    cand_t      cand;
    phase_t     phase;
    logic [7:0] len;
    logic       ovf;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] code;
  } res_t;

  localparam logic [3:0] MATCH_SAT = 4'd8;
  localparam logic [7:0] DEPTH_MAX     = 8'd255;
  localparam logic [7:0] TOKEN_LEN_MAX = 8'd255;

  localparam cand_t CAND_INIT = '{alive: 4'hF, cnt: 4'd0};
  localparam tok_t  TOK_INIT  = '{cand: CAND_INIT, phase: PH_DIGITS, len: 8'd0, ovf: 1'b0};

  // token kinds
  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_RESULT = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // result strings: "1-0", "0-1", "1/2-1/2", "*"
  localparam logic [7:0] CAND_TEXT [4][7] = '{
    '{8'h31, 8'h2D, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h2D, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h2F, 8'h32, 8'h2D, 8'h31, 8'h2F, 8'h32},
    '{8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] CAND_LEN [4] = '{4'd3, 4'd3, 4'd7, 4'd1};

  // first candidate, in list order, that is alive and fully matched
  function automatic res_t tok_result(input cand_t c);
    res_t r;
    r = '{hit: 1'b0, code: 2'd0};
    for (int i = 3; i >= 0; i--) begin
      if (c.alive[i] && c.cnt == CAND_LEN[i]) begin
        r.hit  = 1'b1;
        r.code = 2'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/mtt_cand_match.sv
// ----------------------------------------------------------------------------
// mtt_cand_match: result string matcher
// Advances the four result-string candidates by one token byte.
// ----------------------------------------------------------------------------
module mtt_cand_match
  import mtt_pkg::*;
(
  input  cand_t      cur_i,
  input  logic [7:0] byte_i,
  output cand_t      nxt_o
);

  always_comb begin
    nxt_o = cur_i;
    for (int i = 0; i < 4; i++) begin
      // cnt < len <= 7 before indexing, so the low 3 bits address the text
      if (cur_i.alive[i] &&
          (cur_i.cnt >= CAND_LEN[i] || CAND_TEXT[i][cur_i.cnt[2:0]] != byte_i)) begin
        nxt_o.alive[i] = 1'b0;
      end
    end
    if (cur_i.cnt < MATCH_SAT) begin
      nxt_o.cnt = cur_i.cnt + 4'd1;
    end
  end

endmodule

FILE: sv/movetext_tokenizer.sv
// ----------------------------------------------------------------------------
// movetext_tokenizer: streaming movetext lexer
// Splits one game's movetext into move and result tokens, skipping comments,
// variations, annotations and move numbers.
// ----------------------------------------------------------------------------
// One movetext byte enters per cycle on in_* while out_ready does not hold
// back a waiting word, with in_end_of_game flagging the last byte of a game.
// Each accepted byte is held in an input register; once the result register
// is free or being drained, the lexer state (mode, variation depth, byte
// offset, token tracking) updates from it and any token it completes lands
// in the result register, which drives out_*. The only feedback is the lexer
// state update, and the input register can still take one byte while a
// finished token waits on out_ready. A byte yields at most one word:
// a move (offset and length after stripping move numbers and dots, with
// too_long when the length saturated), a game result (result_code 0 white
// wins, 1 black wins, 2 draw, 3 unfinished), or on the final byte an end
// marker if nothing else is due. The final byte's word always has game_done
// set, and the lexer then returns to its reset state for the next game.
// Bytes after a result are discarded until the final byte. Offsets saturate
// at MOVETEXT_MAX-1 and are reported in 17 bits.
// ----------------------------------------------------------------------------
module movetext_tokenizer
  import mtt_pkg::*;
#(
  parameter int MOVETEXT_MAX = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_game,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_token_kind,
  output logic [1:0]  out_result_code,
  output logic [16:0] out_move_start,
  output logic [7:0]  out_move_length,
  output logic        out_too_long,
  output logic        out_game_done
);

  localparam int PosW = $clog2(MOVETEXT_MAX);
  localparam logic [PosW-1:0] PosLast = PosW'(MOVETEXT_MAX - 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // lexer state
  lex_mode_t       mode_r, mode_nxt;
  logic [7:0]      depth_r, depth_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  tok_t            tok_r, tok_nxt;
  logic [PosW-1:0] bstart_r, bstart_nxt;
  logic            fin_r, fin_nxt;

  // result register
  logic            out_valid_r;
  logic [1:0]      kind_r, code_r;
  logic [PosW-1:0] start_r;
  logic [7:0]      len_r;
  logic            ovf_r, done_r;

  logic            advance;
  tok_t            tok_fresh, tb;
  cand_t           cand_adv;
  logic [PosW-1:0] tb_bstart;
  res_t            res_cur, res_tb;
  logic            is_ws, is_digit;

  logic            emit;
  logic [1:0]      o_kind, o_code;
  logic [PosW-1:0] o_start;
  logic [7:0]      o_len;
  logic            o_ovf;
  logic [PosW+16:0] start_ext;

  // byte moves on when the result slot is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_char_byte;
      last_r <= in_end_of_game;
    end
  end

  // token state as seen by this byte: fresh when a token starts here
  assign tok_fresh = (mode_r == MODE_TOKEN) ? tok_r : TOK_INIT;

  mtt_cand_match u_cand (
    .cur_i  (tok_fresh.cand),
    .byte_i (byte_r),
    .nxt_o  (cand_adv)
  );

  assign is_ws    = byte_r inside {CH_SPACE, [CH_TAB:CH_CR]};
  assign is_digit = byte_r inside {[CH_ZERO:CH_NINE]};

  // token byte: strip leading digits, then dots, then count move bytes
  always_comb begin
    tb        = tok_fresh;
    tb.cand   = cand_adv;
    tb_bstart = (mode_r == MODE_TOKEN) ? bstart_r : '0;
    if (tok_fresh.phase == PH_DIGITS && is_digit) begin
      tb.phase = PH_DIGITS;
    end else if (tok_fresh.phase != PH_BODY && byte_r == CH_DOT) begin
      tb.phase = PH_DOTS;
    end else if (tok_fresh.phase != PH_BODY) begin
      tb.phase  = PH_BODY;
      tb_bstart = pos_r;
      tb.len    = 8'd1;
    end else if (tok_fresh.len < TOKEN_LEN_MAX) begin
      tb.len = tok_fresh.len + 8'd1;
    end else begin
      tb.ovf = 1'b1;
    end
  end

  assign res_cur = tok_result(tok_r.cand);
  assign res_tb  = tok_result(tb.cand);

  // lexer step
  always_comb begin
    mode_nxt   = mode_r;
    depth_nxt  = depth_r;
    pos_nxt    = pos_r;
    tok_nxt    = tok_r;
    bstart_nxt = bstart_r;
    fin_nxt    = fin_r;
    emit       = 1'b0;
    o_kind     = KIND_END;
    o_code     = 2'd0;
    o_start    = '0;
    o_len      = 8'd0;
    o_ovf      = 1'b0;

    if (!fin_r) begin
      case (mode_r)
        MODE_BETWEEN: begin
          if (is_ws || byte_r == CH_RPAREN) begin
            mode_nxt = MODE_BETWEEN;
          end else if (byte_r == CH_LBRACE) begin
            mode_nxt = MODE_COMMENT;
          end else if (byte_r == CH_LPAREN) begin
            mode_nxt  = MODE_VARIATION;
            depth_nxt = 8'd1;
          end else if (byte_r == CH_DOLLAR) begin
            mode_nxt = MODE_NAG;
          end else begin
            mode_nxt   = MODE_TOKEN;
            tok_nxt    = tb;
            bstart_nxt = tb_bstart;
          end
        end
        MODE_TOKEN: begin
          if (is_ws || byte_r == CH_LBRACE || byte_r == CH_LPAREN ||
              byte_r == CH_RPAREN) begin
            mode_nxt = MODE_BETWEEN;
            if (res_cur.hit) begin
              emit    = 1'b1;
              o_kind  = KIND_RESULT;
              o_code  = res_cur.code;
              fin_nxt = 1'b1;
            end else if (tok_r.phase == PH_BODY) begin
              emit    = 1'b1;
              o_kind  = KIND_MOVE;
              o_start = bstart_r;
              o_len   = tok_r.len;
              o_ovf   = tok_r.ovf;
            end
            // delimiter also opens a comment or variation unless game over
            if (!res_cur.hit) begin
              if (byte_r == CH_LBRACE) begin
                mode_nxt = MODE_COMMENT;
              end else if (byte_r == CH_LPAREN) begin
                mode_nxt  = MODE_VARIATION;
                depth_nxt = 8'd1;
              end
            end
          end else begin
            tok_nxt    = tb;
            bstart_nxt = tb_bstart;
          end
        end
        MODE_COMMENT: begin
          if (byte_r == CH_RBRACE) begin
            mode_nxt = MODE_BETWEEN;
          end
        end
        MODE_VARIATION: begin
          if (byte_r == CH_LPAREN) begin
            if (depth_r < DEPTH_MAX) begin
              depth_nxt = depth_r + 8'd1;
            end
          end else if (byte_r == CH_RPAREN) begin
            if (depth_r != 8'd0) begin
              depth_nxt = depth_r - 8'd1;
            end
            if (depth_r <= 8'd1) begin
              mode_nxt = MODE_BETWEEN;
            end
          end else if (byte_r == CH_LBRACE) begin
            mode_nxt = MODE_VAR_COMMENT;
          end
        end
        MODE_VAR_COMMENT: begin
          if (byte_r == CH_RBRACE) begin
            mode_nxt = MODE_VARIATION;
          end
        end
        MODE_NAG: begin
          if (is_ws) begin
            mode_nxt = MODE_BETWEEN;
          end
        end
        default: begin
          mode_nxt = MODE_BETWEEN;
        end
      endcase
    end

    if (last_r) begin
      // final byte inside a token: close it here
      if (!emit && !fin_r && mode_nxt == MODE_TOKEN) begin
        if (res_tb.hit) begin
          emit   = 1'b1;
          o_kind = KIND_RESULT;
          o_code = res_tb.code;
        end else if (tb.phase == PH_BODY) begin
          emit    = 1'b1;
          o_kind  = KIND_MOVE;
          o_start = tb_bstart;
          o_len   = tb.len;
          o_ovf   = tb.ovf;
        end
      end
      emit       = 1'b1;
      mode_nxt   = MODE_BETWEEN;
      depth_nxt  = 8'd0;
      pos_nxt    = '0;
      tok_nxt    = TOK_INIT;
      bstart_nxt = '0;
      fin_nxt    = 1'b0;
    end else if (pos_r != PosLast) begin
      pos_nxt = pos_r + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BETWEEN;
      depth_r  <= 8'd0;
      pos_r    <= '0;
      tok_r    <= TOK_INIT;
      bstart_r <= '0;
      fin_r    <= 1'b0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      depth_r  <= depth_nxt;
      pos_r    <= pos_nxt;
      tok_r    <= tok_nxt;
      bstart_r <= bstart_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r  <= o_kind;
      code_r  <= o_code;
      start_r <= o_start;
      len_r   <= o_len;
      ovf_r   <= o_ovf;
      done_r  <= last_r;
    end
  end

  assign start_ext       = {17'b0, start_r};
  assign out_valid       = out_valid_r;
  assign out_token_kind  = kind_r;
  assign out_result_code = code_r;
  assign out_move_start  = start_ext[16:0];
  assign out_move_length = len_r;
  assign out_too_long    = ovf_r;
  assign out_game_done   = done_r;

  // end marker only ever closes a game
  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_END |-> done_r)
    else $error("end marker without game_done");

  // final byte always yields a word
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_r |=> out_valid_r && done_r)
    else $error("final byte produced no word");

  // final byte returns the lexer to its reset state
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_r |=> mode_r == MODE_BETWEEN && pos_r == '0 && !fin_r &&
      depth_r == 8'd0)
    else $error("lexer not cleared after final byte");

  // after a result the lexer sits between tokens
  a_fin_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> mode_r == MODE_BETWEEN)
    else $error("finished game with active lexer mode");

  // inside a variation the depth is never zero
  a_var_depth: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_VARIATION || mode_r == MODE_VAR_COMMENT |-> depth_r != 8'd0)
    else $error("variation open at depth zero");

endmodule
